>>> rtl/core/gtr_pkg.sv
`timescale 1ns / 1ps

package gtr_pkg;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;

    // index of the closing '$' in the suffix "(?!\n)$"
    localparam logic [2:0] SFX_LAST = 3'd5;

    // One decoded item: optional caret, up to two body bytes, optional suffix.
    typedef struct packed {
        logic       caret;
        logic       v0;
        logic [7:0] b0;
        logic       v1;
        logic [7:0] b1;
        logic       sfx;
    } cmd_t;

    function automatic logic [7:0] sfx_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = CH_LPAREN;
            3'd1:    b = CH_QMARK;
            3'd2:    b = CH_BANG;
            3'd3:    b = CH_LF;
            3'd4:    b = CH_RPAREN;
            default: b = CH_DOLLAR;
        endcase
        return b;
    endfunction

    // regex metacharacters that get a backslash when unescaped
    function automatic logic needs_bslash(input logic [7:0] c);
        return (c == CH_DOT) || (c == CH_PIPE) || (c == CH_PLUS) ||
               (c == CH_LPAREN) || (c == CH_RPAREN) ||
               (c == CH_LBRACE) || (c == CH_RBRACE);
    endfunction

endpackage

>>> rtl/core/glob_to_regex_translator_unit.sv
`timescale 1ns / 1ps
// Path: input word -> command queue -> back-end slot registers -> output register.
// Throughput: one output word per cycle from the back-end emitter while m_tready
//   is high; a symbol word makes 0 to 3 output words, an end word (tlast) 6 or 7,
//   and the next command loads as the last word of the current one is emitted.
// Reset: aresetn low (sync) clears the escape flag, arms the '^' prefix, empties
//   the command queue and drops m_tvalid.

module glob_to_regex_translator_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    // glob input
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic       s_tlast,   // end_mark: pattern ended
    // regex output
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // last: final '$' of the regex
);
    import gtr_pkg::*;

    // front -> queue
    logic q_push;
    cmd_t q_in_cmd;
    logic q_not_full;

    // queue -> back
    logic q_not_empty;
    cmd_t q_head_cmd;
    logic q_pop;

    // Front end: tracks escape / start-of-pattern state and decodes each
    // word into a short command (caret, up to two body bytes, suffix flag).
    gtr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_ready  (q_not_full),
        .q_push   (q_push),
        .q_cmd    (q_in_cmd)
    );

    // Decoupling queue; lets input keep flowing while the back end
    // expands a multi-word command.
    gtr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (q_in_cmd),
        .not_full  (q_not_full),
        .not_empty (q_not_empty),
        .head_cmd  (q_head_cmd),
        .pop       (q_pop)
    );

    // Back end: walks the command slots, one word per cycle unless stalled, into
    // a registered output stage. Next command loads on the final slot.
    gtr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_not_empty),
        .q_cmd    (q_head_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> rtl/core/gtr_front.sv
`timescale 1ns / 1ps

module gtr_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic          s_tlast,
    input  logic          q_ready,
    output logic          q_push,
    output gtr_pkg::cmd_t q_cmd
);
    import gtr_pkg::*;

    logic esc_reg, esc_next;
    logic start_reg, start_next;
    logic accept;
    cmd_t cmd;

    assign s_tready = q_ready;
    assign accept   = s_tvalid && q_ready;

    always_comb begin
        cmd        = '0;
        cmd.caret  = start_reg;
        esc_next   = esc_reg;
        start_next = start_reg;
        if (accept) begin
            start_next = 1'b0;
            priority if (s_tlast) begin
                // flush held backslash, then suffix; rearm for next pattern
                cmd.v0     = esc_reg;
                cmd.b0     = CH_BSLASH;
                cmd.sfx    = 1'b1;
                esc_next   = 1'b0;
                start_next = 1'b1;
            end else if (s_tdata == CH_BSLASH) begin
                if (esc_reg) begin
                    cmd.v0 = 1'b1;
                    cmd.b0 = CH_BSLASH;
                    cmd.v1 = 1'b1;
                    cmd.b1 = CH_BSLASH;
                end
                esc_next = !esc_reg;
            end else if (esc_reg) begin
                esc_next = 1'b0;
                if (s_tdata == CH_STAR || s_tdata == CH_QMARK || s_tdata == CH_LBRACK ||
                    s_tdata == CH_RBRACK || needs_bslash(s_tdata)) begin
                    cmd.v0 = 1'b1;
                    cmd.b0 = CH_BSLASH;
                    cmd.v1 = 1'b1;
                    cmd.b1 = s_tdata;
                end else begin
                    cmd.v0 = 1'b1;
                    cmd.b0 = s_tdata;
                end
            end else if (s_tdata == CH_STAR) begin
                cmd.v0 = 1'b1;
                cmd.b0 = CH_DOT;
                cmd.v1 = 1'b1;
                cmd.b1 = CH_STAR;
            end else if (s_tdata == CH_QMARK) begin
                cmd.v0 = 1'b1;
                cmd.b0 = CH_DOT;
            end else if (needs_bslash(s_tdata)) begin
                cmd.v0 = 1'b1;
                cmd.b0 = CH_BSLASH;
                cmd.v1 = 1'b1;
                cmd.b1 = s_tdata;
            end else begin
                cmd.v0 = 1'b1;
                cmd.b0 = s_tdata;
            end
        end
    end

    // items that produce nothing (a held backslash) never reach the queue
    assign q_push = accept && (cmd.caret || cmd.v0 || cmd.v1 || cmd.sfx);
    assign q_cmd  = cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_reg   <= 1'b0;
            start_reg <= 1'b1;
        end else begin
            esc_reg   <= esc_next;
            start_reg <= start_next;
        end
    end

endmodule

>>> rtl/core/gtr_fifo.sv
`timescale 1ns / 1ps

module gtr_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  gtr_pkg::cmd_t push_cmd,
    output logic          not_full,
    output logic          not_empty,
    output gtr_pkg::cmd_t head_cmd,
    input  logic          pop
);
    import gtr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          slot_reg [DEPTH];
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [AW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign not_full  = (cnt_reg != FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign head_cmd  = slot_reg[rptr_reg];
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == LAST_PTR) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == LAST_PTR) ? '0 : rptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

>>> rtl/core/gtr_back.sv
`timescale 1ns / 1ps

module gtr_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  gtr_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic          m_tlast
);
    import gtr_pkg::*;

    // remaining slots of the current command: {b1, b0, caret}
    logic [2:0] rem_reg, rem_next, rem_after;
    logic [7:0] b0_reg, b0_next;
    logic [7:0] b1_reg, b1_next;
    logic       sfx_reg, sfx_next;
    logic [2:0] sidx_reg, sidx_next;
    logic       mvalid_reg, mvalid_next;
    logic [7:0] mdata_reg, mdata_next;
    logic       mlast_reg, mlast_next;

    logic       busy, out_free, emit, final_slot, load;
    logic [7:0] sel_byte;
    logic       sel_last;

    assign busy     = (rem_reg != '0) || sfx_reg;
    assign out_free = !mvalid_reg || m_tready;
    assign emit     = busy && out_free;
    assign load     = q_valid && (!busy || (emit && final_slot));
    assign q_pop    = load;

    always_comb begin
        rem_after  = rem_reg;
        sel_byte   = sfx_byte(sidx_reg);
        sel_last   = 1'b0;
        final_slot = 1'b0;
        priority if (rem_reg[0]) begin
            sel_byte     = CH_CARET;
            rem_after[0] = 1'b0;
            final_slot   = (rem_after == '0) && !sfx_reg;
        end else if (rem_reg[1]) begin
            sel_byte     = b0_reg;
            rem_after[1] = 1'b0;
            final_slot   = (rem_after == '0) && !sfx_reg;
        end else if (rem_reg[2]) begin
            sel_byte     = b1_reg;
            rem_after[2] = 1'b0;
            final_slot   = !sfx_reg;
        end else begin
            sel_last   = (sidx_reg == SFX_LAST);
            final_slot = sel_last;
        end
    end

    always_comb begin
        rem_next    = rem_reg;
        b0_next     = b0_reg;
        b1_next     = b1_reg;
        sfx_next    = sfx_reg;
        sidx_next   = sidx_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        mlast_next  = mlast_reg;

        if (emit) begin
            if (rem_reg != '0) begin
                rem_next = rem_after;
            end else if (sel_last) begin
                sfx_next  = 1'b0;
                sidx_next = '0;
            end else begin
                sidx_next = sidx_reg + 1'b1;
            end
        end

        if (load) begin
            rem_next  = {q_cmd.v1, q_cmd.v0, q_cmd.caret};
            b0_next   = q_cmd.b0;
            b1_next   = q_cmd.b1;
            sfx_next  = q_cmd.sfx;
            sidx_next = '0;
        end

        if (out_free) begin
            mvalid_next = emit;
            mdata_next  = sel_byte;
            mlast_next  = sel_last;
        end
    end

    always_ff @(posedge aclk) begin
        b0_reg    <= b0_next;
        b1_reg    <= b1_next;
        mdata_reg <= mdata_next;
        mlast_reg <= mlast_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg    <= '0;
            sfx_reg    <= 1'b0;
            sidx_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            rem_reg    <= rem_next;
            sfx_reg    <= sfx_next;
            sidx_reg   <= sidx_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;

endmodule

>>> rtl/core/gtr_checker.sv
`timescale 1ns / 1ps

module gtr_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);
    import gtr_pkg::*;

    // the regex always closes on '$'
    a_last_is_dollar: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == CH_DOLLAR)
        else $error("m_tlast on a word other than '$'");

    // a word following a closed regex opens the next one with '^'
    a_caret_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast ##1 m_tvalid |-> m_tdata == CH_CARET)
        else $error("regex does not start with '^'");

    // output is empty right after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // stalled input word holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
        else $error("input word changed while stalled");

endmodule

bind glob_to_regex_translator_unit gtr_checker u_gtr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
